// ===== design/sil_pkg.sv =====
package sil_pkg;

  localparam int CAPACITY    = 32;
  localparam int MAX_RESULTS = 32;
  localparam int EMIT_MAX    = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef logic signed [31:0] word_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_VALUE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PLACE,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    cell_op_t op;
    logic     append;
    word_t    v;
    cnt_t     count;
  } cell_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    word_t      value_in;
  } in_item_t;

  typedef struct packed {
    word_t      value_out;
    logic       last_of_run;
    logic [1:0] status;
  } out_item_t;

endpackage

// ===== design/sil_cell.sv =====
module sil_cell import sil_pkg::*; (
  input  logic      clk,
  input  idx_t      pos,
  input  cell_cmd_t cmd,
  input  word_t     left_value,
  input  logic      left_lt,
  input  word_t     right_value,
  input  word_t     head_value,
  output word_t     value,
  output logic      lt
);

  cnt_t  pos_ext;
  logic  occupied;
  logic  tail;
  word_t value_next;

  assign pos_ext  = CNT_W'(pos);
  assign occupied = pos_ext < cmd.count;
  assign tail     = (pos_ext + CNT_W'(1)) == cmd.count;
  // append treats every stored entry as smaller than the new value
  // the run of smaller entries ends at the first cell that breaks it, so an
  // unsorted list built by appends still inserts at the first such cell
  assign lt       = left_lt && occupied && (cmd.append || (value < cmd.v));

  always_comb begin
    value_next = value;
    case (cmd.op)
      CELL_PLACE: begin
        if (lt) begin
          value_next = value;
        end else if (left_lt) begin
          value_next = cmd.v;
        end else begin
          value_next = left_value;
        end
      end
      CELL_ROTATE: begin
        if (occupied) begin
          value_next = tail ? head_value : right_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== design/sil_chain.sv =====
module sil_chain import sil_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  output word_t     head
);

  word_t values [CAPACITY];
  logic  lts    [CAPACITY];

  assign head = values[0];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t left_v;
    logic  left_l;
    word_t right_v;

    if (g == 0) begin : g_first
      // nothing stands before the first cell
      assign left_v = '0;
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_v = values[g-1];
      assign left_l = lts[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_v = values[0];
    end else begin : g_inner
      assign right_v = values[g+1];
    end

    sil_cell u_cell (
      .clk         (clk),
      .pos         (IDX_W'(g)),
      .cmd         (cmd),
      .left_value  (left_v),
      .left_lt     (left_l),
      .right_value (right_v),
      .head_value  (values[0]),
      .value       (values[g]),
      .lt          (lts[g])
    );
  end

endmodule

// ===== design/sorted_insert_list.sv =====
// sorted insert list: keeps up to CAPACITY signed 32-bit values in a row of cells.
// a transaction is taken at a clock edge where start is high and busy is low.
// append and insert finish in the cell row at the accepting edge; their single
// status result shows on result in the next cycle, marked by strobe, so such a
// transaction can follow in every cycle. a readout holds busy high while the cells
// rotate the list past cell zero, one step per stored entry; values come out one
// per cycle, the first once the state has turned to read and the result register
// has taken cell zero, and the rotation leaves the list in its original order.
// an empty readout, a full store and the unused function code each answer one
// result in the next cycle. strobe is high for exactly one cycle per result and
// the receiver cannot stall: every strobed result must be taken as it appears.
module sorted_insert_list import sil_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item,
  output logic      strobe,
  output out_item_t result
);

  state_t    state;
  state_t    state_next;
  cnt_t      count;
  cnt_t      count_next;
  cnt_t      idx;
  cnt_t      idx_next;
  cnt_t      emit_n;
  logic      accept;
  logic      full;
  logic      strobe_next;
  out_item_t result_next;
  cell_cmd_t cmd;
  word_t     head;

  assign busy   = (state == S_READ);
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(CAPACITY));
  // number of values a readout actually emits
  assign emit_n = (count > CNT_W'(EMIT_MAX)) ? CNT_W'(EMIT_MAX) : count;

  sil_chain u_chain (
    .clk  (clk),
    .cmd  (cmd),
    .head (head)
  );

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    strobe_next = 1'b0;
    result_next = '{value_out: '0, last_of_run: 1'b1, status: ST_OK};
    cmd         = '{op: CELL_HOLD, append: 1'b0, v: item.value_in, count: count};
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.func)
            FUNC_APPEND, FUNC_INSERT: begin
              strobe_next = 1'b1;
              if (full) begin
                result_next.status = ST_FULL;
              end else begin
                cmd.op     = CELL_PLACE;
                cmd.append = (item.func == FUNC_APPEND);
                count_next = count + CNT_W'(1);
              end
            end
            FUNC_READ: begin
              if (count == '0) begin
                strobe_next        = 1'b1;
                result_next.status = ST_EMPTY;
              end else begin
                // the read state registers the first value from cell zero
                state_next = S_READ;
                idx_next   = '0;
              end
            end
            default: begin
              // unused code: plain ack, nothing changes
              strobe_next = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.op                  = CELL_ROTATE;
        strobe_next             = (idx < emit_n);
        result_next.value_out   = head;
        result_next.status      = ST_VALUE;
        result_next.last_of_run = (idx == emit_n - CNT_W'(1));
        if (idx == count - CNT_W'(1)) begin
          state_next = S_IDLE;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      idx    <= idx_next;
      strobe <= strobe_next;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // fill level never runs past the store size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  // the readout index stays among stored entries and the list does not change size
  a_read_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (idx < count) && (count != '0) && $stable(count))
    else $error("readout index out of range");

  // a placed value is acked ok in the next cycle and grows the list by one
  a_place_ack: assert property (@(posedge clk) disable iff (rst)
    (accept && !full && (item.func == FUNC_APPEND || item.func == FUNC_INSERT))
    |=> (strobe && result.status == ST_OK && result.last_of_run
         && count == $past(count) + CNT_W'(1)))
    else $error("missing ack after placing a value");

  // an empty readout answers one empty result and stays idle
  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (accept && item.func == FUNC_READ && count == '0)
    |=> (strobe && result.status == ST_EMPTY && state == S_IDLE))
    else $error("empty readout not flagged");

endmodule
